>>> rtl/core/ntc_thermistor_temperature_macros.svh
// Assertion macros for the NTC thermistor temperature block.
// Depends on a clock named clk and a synchronous active-low reset named rst_n.
`ifndef NTC_THERMISTOR_TEMPERATURE_MACROS_SVH
`define NTC_THERMISTOR_TEMPERATURE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NTC_ASSERT_IMP(lbl, ante, cons)
`define NTC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/ntc_pkg.sv
// Constants, codes and types of the NTC thermistor temperature block.
// Used by ntc_thermistor_temperature; depends on nothing.
`default_nettype none
package ntc_pkg;
  localparam int AVG_DEPTH  = 16;
  localparam int FULL_SCALE = 4095;
  localparam int FS_TOTAL   = FULL_SCALE * AVG_DEPTH;
  localparam int SUM_W      = $clog2(FS_TOTAL + 1);
  localparam int POS_W      = $clog2(AVG_DEPTH);
  localparam int CODE_W     = 12;
  localparam int OHM_W      = 20;
  localparam int BETA_W     = 14;
  localparam int T0_W       = 16;
  localparam int TEMP_W     = 15;
  localparam int INVALID_LO = AVG_DEPTH;
  localparam int INVALID_HI = 4094 * AVG_DEPTH;
  localparam int LN2_Q30    = 744261118;
  localparam int ZERO_C_CK  = 27315;

  typedef logic [1:0] status_t;
  typedef logic signed [TEMP_W-1:0] temp_t;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_INVALID = 2'd1;
  localparam status_t STATUS_HOT     = 2'd2;
  localparam status_t STATUS_COLD    = 2'd3;

  localparam temp_t TEMP_MIN = -15'sd4000;
  localparam temp_t TEMP_MAX = 15'sd15000;

  localparam logic [2:0] REG_SERIES  = 3'd0;
  localparam logic [2:0] REG_NOMINAL = 3'd1;
  localparam logic [2:0] REG_BETA    = 3'd2;
  localparam logic [2:0] REG_T0      = 3'd3;
  localparam logic [2:0] REG_HOT     = 3'd4;
  localparam logic [2:0] REG_COLD    = 3'd5;
endpackage
`default_nettype wire

>>> rtl/core/ntc_thermistor_temperature.sv
// NTC thermistor temperature: moving average, divider resistance and beta equation.
// Depends on ntc_pkg and ntc_thermistor_temperature_macros.svh.
//
//  channel  | signals                                          | dir
//  in       | in_valid, in_ready, in_sample_code               | in
//  out      | out_valid, out_ready, out_temp_centi, out_status, | out
//           | out_average_code                                 |
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data        | in
//
// A new sample is taken only in the idle state. When the beta equation is
// evaluated, an item runs two 24-step logarithms on the shared 32x32 multiplier
// and the 21-step divider; invalid or clamped readings skip the divider.
// Reset is synchronous; it clears ring, sum and out_valid and loads cfg defaults.
// The result waits in an output register; a stalled output holds the sequencer.
`default_nettype none
`include "ntc_thermistor_temperature_macros.svh"
module ntc_thermistor_temperature (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [ntc_pkg::CODE_W-1:0]   in_sample_code,
  output logic                         out_valid,
  input  wire                          out_ready,
  output ntc_pkg::temp_t               out_temp_centi,
  output ntc_pkg::status_t             out_status,
  output logic [ntc_pkg::CODE_W-1:0]   out_average_code,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [2:0]                   cfg_index,
  input  wire  [ntc_pkg::OHM_W-1:0]    cfg_data
);
  localparam int X_W   = 36;
  localparam int DIV_W = 69;
  localparam int DD_W  = 48;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHK   = 5'd1;
  localparam logic [4:0] S_MNUM  = 5'd2;
  localparam logic [4:0] S_MHOT  = 5'd3;
  localparam logic [4:0] S_MCOLD = 5'd4;
  localparam logic [4:0] S_MNOM  = 5'd5;
  localparam logic [4:0] S_LOGST = 5'd6;
  localparam logic [4:0] S_NORM  = 5'd7;
  localparam logic [4:0] S_NORMD = 5'd8;
  localparam logic [4:0] S_SQ0   = 5'd9;
  localparam logic [4:0] S_SQ    = 5'd10;
  localparam logic [4:0] S_LN2   = 5'd11;
  localparam logic [4:0] S_LQ    = 5'd12;
  localparam logic [4:0] S_DD    = 5'd13;
  localparam logic [4:0] S_N     = 5'd14;
  localparam logic [4:0] S_DIV   = 5'd15;
  localparam logic [4:0] S_TEMP  = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;

  logic [4:0]                        state_r, state_nxt;
  logic [ntc_pkg::CODE_W-1:0]        ring_r [ntc_pkg::AVG_DEPTH];
  logic [ntc_pkg::POS_W-1:0]         wp_r;
  logic [ntc_pkg::SUM_W-1:0]         sum_r, sum_nxt;
  logic [ntc_pkg::OHM_W-1:0]         series_r, nominal_r, hot_r, cold_r;
  logic [ntc_pkg::BETA_W-1:0]        beta_r;
  logic [ntc_pkg::T0_W-1:0]          t0_r;
  logic                              out_valid_r;
  ntc_pkg::temp_t                    out_temp_r;
  ntc_pkg::status_t                  out_status_r;
  logic [ntc_pkg::CODE_W-1:0]        out_avg_r;

  logic [ntc_pkg::SUM_W-1:0]         d_r, d_nxt;
  logic [X_W-1:0]                    num_r, num_nxt, den_r, den_nxt, x_r, x_nxt;
  logic [5:0]                        sh_r, sh_nxt;
  logic [2:0]                        step_r, step_nxt;
  logic [30:0]                       m_r, m_nxt;
  logic [5:0]                        exp_r, exp_nxt;
  logic [23:0]                       frac_r, frac_nxt;
  logic [4:0]                        bit_r, bit_nxt;
  logic                              sel_r, sel_nxt;
  logic [29:0]                       lognum_r, lognum_nxt;
  logic [29:0]                       dmag_r, dmag_nxt;
  logic                              dneg_r, dneg_nxt;
  logic signed [DD_W-1:0]            dd_r, dd_nxt;
  logic [DIV_W-1:0]                  rem_r, rem_nxt, div_r, div_nxt;
  logic [20:0]                       q_r, q_nxt;
  ntc_pkg::temp_t                    res_temp_r, res_temp_nxt;
  ntc_pkg::status_t                  res_status_r, res_status_nxt;

  logic [31:0]                       mul_a, mul_b;
  logic [63:0]                       prod_r;

  logic [20:0]                       b100;
  logic [5:0]                        sh_amt;
  logic [31:0]                       sq_t;
  logic [30:0]                       sq_m;
  logic                              sq_bit;
  logic [29:0]                       log_val;
  logic signed [30:0]                log_diff;
  logic [DIV_W-1:0]                  nprime;
  logic signed [22:0]                t_ck;
  logic                              accept, load_out;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign b100      = {1'b0, beta_r, 6'b0} + {2'b0, beta_r, 5'b0} + {5'b0, beta_r, 2'b0};
  assign sh_amt    = 6'd32 >> step_r;
  assign sq_t      = prod_r[61:30];
  assign sq_m      = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
  assign sq_bit    = sq_t[31];
  assign log_val   = {exp_r, frac_nxt};
  assign log_diff  = signed'({1'b0, lognum_r}) - signed'({1'b0, log_val});
  assign nprime    = DIV_W'({prod_r[36:0], 24'b0}) + DIV_W'(dd_r >>> 1);
  assign t_ck      = signed'({2'b0, q_r}) - 23'sd27315;

  always_comb begin
    state_nxt      = state_r;
    sum_nxt        = sum_r;
    d_nxt          = d_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    x_nxt          = x_r;
    sh_nxt         = sh_r;
    step_nxt       = step_r;
    m_nxt          = m_r;
    exp_nxt        = exp_r;
    frac_nxt       = frac_r;
    bit_nxt        = bit_r;
    sel_nxt        = sel_r;
    lognum_nxt     = lognum_r;
    dmag_nxt       = dmag_r;
    dneg_nxt       = dneg_r;
    dd_nxt         = dd_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    q_nxt          = q_r;
    res_temp_nxt   = res_temp_r;
    res_status_nxt = res_status_r;
    mul_a          = '0;
    mul_b          = '0;
    if (state_r == S_SQ) begin
      frac_nxt = frac_r | (24'(sq_bit) << bit_r);
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          sum_nxt   = sum_r - ntc_pkg::SUM_W'(ring_r[wp_r])
                      + ntc_pkg::SUM_W'(in_sample_code);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        d_nxt = ntc_pkg::SUM_W'(ntc_pkg::FS_TOTAL) - sum_r;
        if (sum_r <= ntc_pkg::SUM_W'(ntc_pkg::INVALID_LO)
            || 32'(sum_r) >= 32'(ntc_pkg::INVALID_HI)
            || 32'(sum_r) >= 32'(ntc_pkg::FS_TOTAL)) begin
          res_status_nxt = ntc_pkg::STATUS_INVALID;
          res_temp_nxt   = '0;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_MNUM;
        end
      end
      S_MNUM: begin
        mul_a     = 32'(series_r);
        mul_b     = 32'(sum_r);
        state_nxt = S_MHOT;
      end
      S_MHOT: begin
        num_nxt   = prod_r[X_W-1:0];
        mul_a     = 32'(hot_r);
        mul_b     = 32'(d_r);
        state_nxt = S_MCOLD;
      end
      S_MCOLD: begin
        if (num_r <= prod_r[X_W-1:0]) begin
          res_status_nxt = ntc_pkg::STATUS_HOT;
          res_temp_nxt   = ntc_pkg::TEMP_MAX;
          state_nxt      = S_FIN;
        end else begin
          mul_a     = 32'(cold_r);
          mul_b     = 32'(d_r);
          state_nxt = S_MNOM;
        end
      end
      S_MNOM: begin
        if (num_r >= prod_r[X_W-1:0]) begin
          res_status_nxt = ntc_pkg::STATUS_COLD;
          res_temp_nxt   = ntc_pkg::TEMP_MIN;
          state_nxt      = S_FIN;
        end else if (nominal_r == '0) begin
          res_status_nxt = ntc_pkg::STATUS_OK;
          res_temp_nxt   = ntc_pkg::TEMP_MIN;
          state_nxt      = S_FIN;
        end else begin
          mul_a     = 32'(nominal_r);
          mul_b     = 32'(d_r);
          state_nxt = S_LOGST;
        end
      end
      S_LOGST: begin
        den_nxt   = prod_r[X_W-1:0];
        x_nxt     = num_r;
        sel_nxt   = 1'b0;
        sh_nxt    = '0;
        step_nxt  = '0;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if ((x_r >> (6'(X_W) - sh_amt)) == '0) begin
          x_nxt  = x_r << sh_amt;
          sh_nxt = sh_r + sh_amt;
        end
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd5) begin
          state_nxt = S_NORMD;
        end
      end
      S_NORMD: begin
        m_nxt     = x_r[X_W-1:X_W-31];
        exp_nxt   = 6'(X_W - 1) - sh_r;
        frac_nxt  = '0;
        bit_nxt   = 5'd23;
        state_nxt = S_SQ0;
      end
      S_SQ0: begin
        mul_a     = 32'(m_r);
        mul_b     = 32'(m_r);
        state_nxt = S_SQ;
      end
      S_SQ: begin
        m_nxt = sq_m;
        if (bit_r == '0) begin
          if (!sel_r) begin
            lognum_nxt = log_val;
            x_nxt      = den_r;
            sel_nxt    = 1'b1;
            sh_nxt     = '0;
            step_nxt   = '0;
            state_nxt  = S_NORM;
          end else begin
            dneg_nxt  = log_diff[30];
            dmag_nxt  = log_diff[30] ? 30'(-log_diff) : log_diff[29:0];
            state_nxt = S_LN2;
          end
        end else begin
          bit_nxt = bit_r - 5'd1;
          mul_a   = 32'(sq_m);
          mul_b   = 32'(sq_m);
        end
      end
      S_LN2: begin
        mul_a     = 32'(dmag_r);
        mul_b     = 32'(ntc_pkg::LN2_Q30);
        state_nxt = S_LQ;
      end
      S_LQ: begin
        mul_a     = 32'(t0_r);
        mul_b     = 32'(prod_r[59:30]);
        state_nxt = S_DD;
      end
      S_DD: begin
        if (dneg_r) begin
          dd_nxt = signed'(DD_W'({b100, 24'b0})) - signed'(DD_W'(prod_r[45:0]));
        end else begin
          dd_nxt = signed'(DD_W'({b100, 24'b0})) + signed'(DD_W'(prod_r[45:0]));
        end
        mul_a     = 32'(b100);
        mul_b     = 32'(t0_r);
        state_nxt = S_N;
      end
      S_N: begin
        res_status_nxt = ntc_pkg::STATUS_OK;
        if (dd_r[DD_W-1] || dd_r == '0) begin
          res_temp_nxt = ntc_pkg::TEMP_MAX;
          state_nxt    = S_FIN;
        end else if (nprime >= (DIV_W'(dd_r) << 21)) begin
          res_temp_nxt = ntc_pkg::TEMP_MAX;
          state_nxt    = S_FIN;
        end else begin
          rem_nxt   = nprime;
          div_nxt   = DIV_W'(dd_r) << 20;
          q_nxt     = '0;
          bit_nxt   = 5'd20;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_r >= div_r) begin
          rem_nxt = rem_r - div_r;
          q_nxt   = {q_r[19:0], 1'b1};
        end else begin
          q_nxt = {q_r[19:0], 1'b0};
        end
        div_nxt = div_r >> 1;
        if (bit_r == '0) begin
          state_nxt = S_TEMP;
        end else begin
          bit_nxt = bit_r - 5'd1;
        end
      end
      S_TEMP: begin
        priority if (t_ck < 23'(signed'(ntc_pkg::TEMP_MIN))) begin
          res_temp_nxt = ntc_pkg::TEMP_MIN;
        end else if (t_ck > 23'(signed'(ntc_pkg::TEMP_MAX))) begin
          res_temp_nxt = ntc_pkg::TEMP_MAX;
        end else begin
          res_temp_nxt = t_ck[ntc_pkg::TEMP_W-1:0];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      series_r    <= ntc_pkg::OHM_W'(10000);
      nominal_r   <= ntc_pkg::OHM_W'(10000);
      beta_r      <= ntc_pkg::BETA_W'(3950);
      t0_r        <= ntc_pkg::T0_W'(29815);
      hot_r       <= ntc_pkg::OHM_W'(200);
      cold_r      <= ntc_pkg::OHM_W'(50000);
      for (int i = 0; i < ntc_pkg::AVG_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      if (accept) begin
        ring_r[wp_r] <= in_sample_code;
        wp_r <= (wp_r == ntc_pkg::POS_W'(ntc_pkg::AVG_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ntc_pkg::REG_SERIES:  series_r  <= cfg_data;
          ntc_pkg::REG_NOMINAL: nominal_r <= cfg_data;
          ntc_pkg::REG_BETA:    beta_r    <= cfg_data[ntc_pkg::BETA_W-1:0];
          ntc_pkg::REG_T0:      t0_r      <= cfg_data[ntc_pkg::T0_W-1:0];
          ntc_pkg::REG_HOT:     hot_r     <= cfg_data;
          ntc_pkg::REG_COLD:    cold_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= mul_a * mul_b;
    d_r          <= d_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    x_r          <= x_nxt;
    sh_r         <= sh_nxt;
    step_r       <= step_nxt;
    m_r          <= m_nxt;
    exp_r        <= exp_nxt;
    frac_r       <= frac_nxt;
    bit_r        <= bit_nxt;
    sel_r        <= sel_nxt;
    lognum_r     <= lognum_nxt;
    dmag_r       <= dmag_nxt;
    dneg_r       <= dneg_nxt;
    dd_r         <= dd_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    q_r          <= q_nxt;
    res_temp_r   <= res_temp_nxt;
    res_status_r <= res_status_nxt;
    if (load_out) begin
      out_temp_r   <= res_temp_r;
      out_status_r <= res_status_r;
      out_avg_r    <= ntc_pkg::CODE_W'(sum_r / ntc_pkg::AVG_DEPTH);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_temp_centi   = out_temp_r;
  assign out_status       = out_status_r;
  assign out_average_code = out_avg_r;

  `NTC_ASSERT_NXT(a_busy_after_item, in_valid && in_ready, !in_ready)
  `NTC_ASSERT_IMP(a_hot_clamp, out_valid && out_status == ntc_pkg::STATUS_HOT,
                  out_temp_centi == ntc_pkg::TEMP_MAX)
  `NTC_ASSERT_IMP(a_cold_clamp, out_valid && out_status == ntc_pkg::STATUS_COLD,
                  out_temp_centi == ntc_pkg::TEMP_MIN)
  `NTC_ASSERT_IMP(a_invalid_zero, out_valid && out_status == ntc_pkg::STATUS_INVALID,
                  out_temp_centi == '0)
endmodule
`default_nettype wire
